// ===== rtl/core/slcd_pkg.sv =====
`default_nettype none
package slcd_pkg;

  localparam int MAX_PAYLOAD = 120;
  localparam int WORD_BYTES  = 8;
  localparam int RAM_DEPTH   = 2 * MAX_PAYLOAD;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int DESC_DEPTH  = 2;

  // configuration register indexes
  localparam logic [1:0] CFG_HEAD_FIRST  = 2'd0;
  localparam logic [1:0] CFG_HEAD_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN     = 2'd2;

  // result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_WORD   = 1'b1;

  typedef struct packed {
    logic [7:0] head_first;
    logic [7:0] head_second;
    logic [6:0] max_len;
  } cfg_t;

  // one good frame waiting for the back side
  typedef struct packed {
    logic [7:0] cmd;
    logic [6:0] len;
    logic       bank;
  } desc_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

endpackage
`default_nettype wire

// ===== rtl/core/slcd_in_if.sv =====
`default_nettype none
interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/slcd_out_if.sv =====
`default_nettype none
interface slcd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  command_code;
  logic [6:0]  payload_length;
  logic [63:0] payload_word;
  logic [3:0]  word_bytes;
  logic        last;

  modport source (output valid, output kind, output command_code, output payload_length,
                  output payload_word, output word_bytes, output last, input ready);
  modport sink (input valid, input kind, input command_code, input payload_length,
                input payload_word, input word_bytes, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/slcd_ram.sv =====
`default_nettype none
module slcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 240
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/slcd_front.sv =====
`default_nettype none
module slcd_front import slcd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  slcd_in_if.sink   in_ch,
  input  wire logic q_full,
  output logic      q_push,
  output desc_t     q_desc,
  output ram_wr_t   ram_wr
);

  localparam logic [3:0] PH_HUNT  = 4'd0;
  localparam logic [3:0] PH_GOTH1 = 4'd1;
  localparam logic [3:0] PH_CMD   = 4'd2;
  localparam logic [3:0] PH_LEN   = 4'd3;
  localparam logic [3:0] PH_DATA  = 4'd4;
  localparam logic [3:0] PH_SUML  = 4'd5;
  localparam logic [3:0] PH_SUMH  = 4'd6;
  localparam logic [3:0] PH_TAIL1 = 4'd7;
  localparam logic [3:0] PH_TAIL2 = 4'd8;

  typedef struct packed {
    logic [3:0] phase;
    logic [7:0] cmd;
  } hunt_t;

  function automatic hunt_t hunt_feed(hunt_t s, logic [7:0] b, logic [7:0] h1,
                                      logic [7:0] h2);
    hunt_t r;
    r = s;
    if (s.phase == PH_HUNT) begin
      if (b == h1) r.phase = PH_GOTH1;
    end else if (s.phase == PH_GOTH1) begin
      if (b == h2) r.phase = PH_CMD;
      else if (b != h1) r.phase = PH_HUNT;
    end else if (s.phase == PH_CMD) begin
      r.cmd   = b;
      r.phase = PH_LEN;
    end
    return r;
  endfunction

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic        ok_r, ok_nxt;
  logic        bank_r, bank_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [6:0]  limit;
  logic [6:0]  cnt_inc;
  hunt_t       h0, h1, h2, h3, hs;

  // hold off only where a new frame would claim a payload bank
  assign in_ch.ready = !(phase_r == PH_LEN && q_full);
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign limit       = (cfg.max_len > 7'(MAX_PAYLOAD)) ? 7'(MAX_PAYLOAD) : cfg.max_len;
  assign cnt_inc     = cnt_r + 7'd1;

  // length too large: replay head_second, cmd and the length byte through the hunt
  always_comb begin
    h0 = '{phase: PH_HUNT, cmd: cmd_r};
    h1 = hunt_feed(h0, cfg.head_second, cfg.head_first, cfg.head_second);
    h2 = hunt_feed(h1, cmd_r, cfg.head_first, cfg.head_second);
    h3 = hunt_feed(h2, b, cfg.head_first, cfg.head_second);
    hs = hunt_feed('{phase: phase_r, cmd: cmd_r}, b, cfg.head_first, cfg.head_second);
  end

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    ok_nxt    = ok_r;
    bank_nxt  = bank_r;
    q_push    = 1'b0;
    q_desc    = '{cmd: cmd_r, len: len_r, bank: bank_r};
    ram_wr.we   = 1'b0;
    ram_wr.addr = (bank_r ? RAM_AW'(MAX_PAYLOAD) : '0) + RAM_AW'(cnt_r);
    ram_wr.data = b;
    if (accept) begin
      unique case (phase_r)
        PH_HUNT, PH_GOTH1, PH_CMD: begin
          phase_nxt = hs.phase;
          cmd_nxt   = hs.cmd;
        end
        PH_LEN: begin
          if (b > {1'b0, limit}) begin
            phase_nxt = h3.phase;
            cmd_nxt   = h3.cmd;
          end else begin
            len_nxt   = b[6:0];
            cnt_nxt   = '0;
            ok_nxt    = 1'b1;
            sum_nxt   = {8'd0, cmd_r} + {8'd0, b};
            phase_nxt = (b != 8'd0) ? PH_DATA : PH_SUML;
          end
        end
        PH_DATA: begin
          ram_wr.we = 1'b1;
          sum_nxt   = sum_r + {8'd0, b};
          cnt_nxt   = cnt_inc;
          if (cnt_inc >= len_r) phase_nxt = PH_SUML;
        end
        PH_SUML: begin
          if (b != sum_r[7:0]) ok_nxt = 1'b0;
          phase_nxt = PH_SUMH;
        end
        PH_SUMH: begin
          if (b != sum_r[15:8]) ok_nxt = 1'b0;
          phase_nxt = PH_TAIL1;
        end
        PH_TAIL1: begin
          if (b != cfg.head_second) ok_nxt = 1'b0;
          phase_nxt = PH_TAIL2;
        end
        PH_TAIL2: begin
          if (ok_r && b == cfg.head_first) begin
            q_push   = 1'b1;
            bank_nxt = !bank_r;
          end
          ok_nxt    = 1'b1;
          phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cmd_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      ok_r    <= 1'b1;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      ok_r    <= ok_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/slcd_fifo.sv =====
`default_nettype none
module slcd_fifo import slcd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output desc_t      head_desc,
  output logic       full,
  output logic       empty
);

  localparam int PW = $clog2(DESC_DEPTH);

  desc_t             ent_r [DESC_DEPTH];
  logic [PW-1:0]     wp_r, rp_r;
  logic [PW:0]       cnt_r;

  assign full      = cnt_r == (PW+1)'(DESC_DEPTH);
  assign empty     = cnt_r == '0;
  assign head_desc = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop) rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  // the front holds off at the length byte, so a push never meets a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("descriptor queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("descriptor queue underflow");

endmodule
`default_nettype wire

// ===== rtl/core/slcd_back.sv =====
`default_nettype none
module slcd_back import slcd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire desc_t             q_desc,
  output logic                   q_pop,
  output logic [RAM_AW-1:0]      ram_raddr,
  input  wire logic [7:0]        ram_rdata,
  slcd_out_if.source             out_ch
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_HEAD = 2'd1;
  localparam logic [1:0] B_READ = 2'd2;
  localparam logic [1:0] B_WORD = 2'd3;

  logic [1:0]  st_r, st_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [3:0]  iss_r, iss_nxt;
  logic [3:0]  got_r, got_nxt;
  logic        pend_r, pend_nxt;
  logic [63:0] word_r, word_nxt;

  logic        ov_r, ov_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [63:0] pw_r, pw_nxt;
  logic [3:0]  wb_r, wb_nxt;
  logic        last_r, last_nxt;

  logic        slot_free;
  logic        can_issue;

  assign slot_free = !ov_r || out_ch.ready;
  assign can_issue = (iss_r < 4'(WORD_BYTES)) && (pos_r < q_desc.len);
  assign ram_raddr = (q_desc.bank ? RAM_AW'(MAX_PAYLOAD) : '0) + RAM_AW'(pos_r);

  assign out_ch.valid          = ov_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.command_code   = cmd_r;
  assign out_ch.payload_length = len_r;
  assign out_ch.payload_word   = pw_r;
  assign out_ch.word_bytes     = wb_r;
  assign out_ch.last           = last_r;

  always_comb begin
    st_nxt   = st_r;
    pos_nxt  = pos_r;
    iss_nxt  = iss_r;
    got_nxt  = got_r;
    pend_nxt = 1'b0;
    word_nxt = word_r;
    ov_nxt   = ov_r && !out_ch.ready;
    kind_nxt = kind_r;
    cmd_nxt  = cmd_r;
    len_nxt  = len_r;
    pw_nxt   = pw_r;
    wb_nxt   = wb_r;
    last_nxt = last_r;
    q_pop    = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) st_nxt = B_HEAD;
      end
      B_HEAD: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          kind_nxt = KIND_HEADER;
          cmd_nxt  = q_desc.cmd;
          len_nxt  = q_desc.len;
          pw_nxt   = '0;
          wb_nxt   = '0;
          last_nxt = q_desc.len == '0;
          pos_nxt  = '0;
          iss_nxt  = '0;
          got_nxt  = '0;
          word_nxt = '0;
          if (q_desc.len == '0) begin
            q_pop  = 1'b1;
            st_nxt = B_IDLE;
          end else begin
            st_nxt = B_READ;
          end
        end
      end
      B_READ: begin
        // one memory read a cycle, data lands in its byte lane in the next cycle
        if (pend_r) begin
          for (int i = 0; i < WORD_BYTES; i++) begin
            if (got_r == 4'(i)) word_nxt[i*8 +: 8] = ram_rdata;
          end
          got_nxt = got_r + 4'd1;
        end
        if (can_issue) begin
          pend_nxt = 1'b1;
          pos_nxt  = pos_r + 7'd1;
          iss_nxt  = iss_r + 4'd1;
        end else if (!pend_r) begin
          st_nxt = B_WORD;
        end
      end
      B_WORD: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          kind_nxt = KIND_WORD;
          pw_nxt   = word_r;
          wb_nxt   = got_r;
          last_nxt = pos_r == q_desc.len;
          iss_nxt  = '0;
          got_nxt  = '0;
          word_nxt = '0;
          if (pos_r == q_desc.len) begin
            q_pop  = 1'b1;
            st_nxt = B_IDLE;
          end else begin
            st_nxt = B_READ;
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    iss_r  <= iss_nxt;
    got_r  <= got_nxt;
    word_r <= word_nxt;
    kind_r <= kind_nxt;
    cmd_r  <= cmd_nxt;
    len_r  <= len_nxt;
    pw_r   <= pw_nxt;
    wb_r   <= wb_nxt;
    last_r <= last_nxt;
  end

  a_word_bytes: assert property (@(posedge clk) disable iff (!rst_n)
      ov_r && kind_r == KIND_WORD |-> wb_r != 4'd0 && wb_r <= 4'(WORD_BYTES))
    else $error("payload word with bad byte count");

endmodule
`default_nettype wire

// ===== rtl/core/sync_length_checksum_deframer_top.sv =====
`default_nettype none
// Frame parser for a byte stream: hunts for the header pair head_first head_second,
// then takes a command byte, a length byte, that many payload bytes, a 16-bit sum
// (low byte first, command + length + payload mod 65536) and the tail pair
// head_second head_first. A good frame gives one header result and then the payload
// in words of up to eight bytes, earliest byte in bits 7:0; a frame with a bad sum or
// tail is dropped without any result. The front side takes one byte per cycle; it
// holds in_ch.ready low only on the length byte while two good frames still wait for
// or sit in the back side, which owns the two payload banks of a 240-byte memory.
// The back side gives the header result, then reads the payload through its one memory
// read port and packs it into words; results stay in an output register so the
// back side only stalls on out_ch.ready. The memory needs no clearing after reset:
// only bytes written for the current frame are ever read.
module sync_length_checksum_deframer_top import slcd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [7:0] cfg_wdata,
  slcd_in_if.sink         in_ch,
  slcd_out_if.source      out_ch
);

  // configuration registers
  cfg_t    cfg_r;

  // front to queue
  logic    q_push;
  desc_t   q_push_desc;
  logic    q_full;

  // queue to back
  logic    q_pop;
  desc_t   q_head;
  logic    q_empty;

  // payload memory
  ram_wr_t ram_wr;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_first  <= 8'd170;
      cfg_r.head_second <= 8'd85;
      cfg_r.max_len     <= 7'd120;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HEAD_FIRST:  cfg_r.head_first  <= cfg_wdata;
        CFG_HEAD_SECOND: cfg_r.head_second <= cfg_wdata;
        CFG_MAX_LEN:     cfg_r.max_len     <= cfg_wdata[6:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // byte parser, checksum and tail check, payload writes
  slcd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (q_push_desc),
    .ram_wr (ram_wr)
  );

  // good frames waiting for emission, one per payload bank
  slcd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_push_desc),
    .pop       (q_pop),
    .head_desc (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // two banks of payload bytes
  slcd_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // header and payload word results
  slcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_desc    (q_head),
    .q_pop     (q_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_sync_length_checksum_deframer_top.sv =====
`timescale 1ns / 100ps
module tb_sync_length_checksum_deframer_top;
  import slcd_pkg::*;

  // run shape
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either side
  localparam int SETTLE_CYCLES  = 20;    // front side takes a byte per cycle
  localparam int END_CYCLES     = 200;   // longer than one full-size frame on the back side
  localparam int HOLD_CYCLES    = 500;   // long receiver hold-off
  localparam int PHASE_ITEMS    = 26;    // random bytes per configuration setting

  // parser position while walking a frame
  typedef enum logic [3:0] {
    HUNT_H1, HUNT_H2, GET_CMD, GET_LEN, GET_DATA,
    GET_SUM_LO, GET_SUM_HI, GET_TAIL_A, GET_TAIL_B
  } parse_phase_t;

  // shapes of generated frames
  typedef enum logic [1:0] {
    FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_TAIL, FRAME_OVERSIZE
  } frame_kind_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  command_code;
    logic [6:0]  payload_length;
    logic [63:0] payload_word;
    logic [3:0]  word_bytes;
    logic        last;
  } frame_result_t;

  // parser copy plus the queue of results it still owes
  class frame_result_scoreboard;
    logic [7:0]    h1, h2;
    logic [6:0]    max_len;
    parse_phase_t  phase;
    logic [7:0]    cmd;
    logic [6:0]    len;
    logic [6:0]    count;
    logic [15:0]   sum;
    bit            frame_good;
    logic [7:0]    payload [MAX_PAYLOAD];
    frame_result_t expected_results[$];
    int            errors;

    function new();
      h1 = 8'hAA;
      h2 = 8'h55;
      max_len = 7'd120;
      phase = HUNT_H1;
      cmd = '0;
      len = '0;
      count = '0;
      sum = '0;
      frame_good = 1'b1;
      errors = 0;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [7:0] value);
      case (idx)
        CFG_HEAD_FIRST:  h1 = value;
        CFG_HEAD_SECOND: h2 = value;
        CFG_MAX_LEN:     max_len = value[6:0];
        default: ;
      endcase
    endfunction

    // header search, also used for the re-scan after an oversize length
    function void hunt_byte(input logic [7:0] b);
      case (phase)
        HUNT_H1: if (b == h1) phase = HUNT_H2;
        HUNT_H2: begin
          if (b == h2) phase = GET_CMD;
          else if (b != h1) phase = HUNT_H1;
        end
        GET_CMD: begin
          cmd = b;
          phase = GET_LEN;
        end
        default: ;
      endcase
    endfunction

    // header result, then the payload cut into words
    function void release_frame();
      logic [63:0] w;
      int pos, k;
      expected_results.push_back('{kind: KIND_HEADER, command_code: cmd, payload_length: len,
                                   payload_word: '0, word_bytes: '0, last: (len == 0)});
      pos = 0;
      while (pos < len) begin
        w = '0;
        k = 0;
        while (k < WORD_BYTES && pos + k < len) begin
          w |= 64'(payload[pos + k]) << (8 * k);
          k++;
        end
        pos += k;
        expected_results.push_back('{kind: KIND_WORD, command_code: cmd, payload_length: len,
                                     payload_word: w, word_bytes: 4'(k), last: (pos >= len)});
      end
    endfunction

    function void take_byte(input logic [7:0] b);
      int limit;
      logic [7:0] held_cmd;
      limit = (max_len > MAX_PAYLOAD) ? MAX_PAYLOAD : max_len;
      case (phase)
        GET_LEN: begin
          if (b > limit) begin
            held_cmd = cmd;
            phase = HUNT_H1;
            hunt_byte(h2);
            hunt_byte(held_cmd);
            hunt_byte(b);
          end else begin
            len = b[6:0];
            count = '0;
            frame_good = 1'b1;
            sum = {8'h00, cmd} + {8'h00, b};
            phase = (b != 0) ? GET_DATA : GET_SUM_LO;
          end
        end
        GET_DATA: begin
          payload[count] = b;
          sum = sum + {8'h00, b};
          count = count + 7'd1;
          if (count >= len) phase = GET_SUM_LO;
        end
        GET_SUM_LO: begin
          if (b != sum[7:0]) frame_good = 1'b0;
          phase = GET_SUM_HI;
        end
        GET_SUM_HI: begin
          if (b != sum[15:8]) frame_good = 1'b0;
          phase = GET_TAIL_A;
        end
        GET_TAIL_A: begin
          if (b != h2) frame_good = 1'b0;
          phase = GET_TAIL_B;
        end
        GET_TAIL_B: begin
          if (b != h1) frame_good = 1'b0;
          phase = HUNT_H1;
          if (frame_good) release_frame();
          frame_good = 1'b1;
        end
        default: hunt_byte(b);
      endcase
    endfunction

    function void field_check(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(input frame_result_t got);
      frame_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual kind %0d cmd %0h word %0h",
                 $time, got.kind, got.command_code, got.payload_word);
        return;
      end
      want = expected_results.pop_front();
      field_check("kind", 64'(want.kind), 64'(got.kind));
      field_check("command_code", 64'(want.command_code), 64'(got.command_code));
      field_check("payload_length", 64'(want.payload_length), 64'(got.payload_length));
      field_check("payload_word", want.payload_word, got.payload_word);
      field_check("word_bytes", 64'(want.word_bytes), 64'(got.word_bytes));
      field_check("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_addr;
  logic [7:0] cfg_wdata;

  slcd_in_if  in_ch();
  slcd_out_if out_ch();

  frame_result_scoreboard sb = new();

  int tx_count;        // bytes accepted from the stimulus side
  int quiet_cycles;    // cycles since the last transfer on either channel
  bit tx_burst;        // no sender gaps while set
  int rx_hold_len;     // requested receiver hold-off, in cycles
  bit rx_holding;      // receiver is inside a hold-off

  sync_length_checksum_deframer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // both channels are sampled at the edge, before any nonblocking update lands
  always @(posedge clk) begin : channel_monitor
    frame_result_t seen;
    if (rst_n && in_ch.valid && in_ch.ready) sb.take_byte(in_ch.rx_byte);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{kind: out_ch.kind, command_code: out_ch.command_code,
               payload_length: out_ch.payload_length, payload_word: out_ch.payload_word,
               word_bytes: out_ch.word_bytes, last: out_ch.last};
      sb.check_result(seen);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // nothing moving for too long means the block hung
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // receiver: random ready pattern, long ready runs, and hold-offs on request
  initial begin : receiver
    int run, gap, r;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        rx_holding = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
        rx_holding = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        run = (r < 25) ? $urandom_range(50, 200) : $urandom_range(1, 8);
        r = $urandom_range(0, 99);
        if (r < 70) gap = $urandom_range(1, 2);
        else if (r < 95) gap = $urandom_range(3, 8);
        else gap = $urandom_range(20, 60);
        out_ch.ready <= 1'b1;
        repeat (run) @(posedge clk);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  function automatic int frame_limit();
    return (sb.max_len > MAX_PAYLOAD) ? MAX_PAYLOAD : sb.max_len;
  endfunction

  // mostly short payloads, now and then up to the limit
  function automatic int pick_len(input int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, (lim < 10) ? lim : 10);
    if (r < 95) return $urandom_range(0, (lim < 40) ? lim : 40);
    return $urandom_range(0, lim);
  endfunction

  // one byte transfer; valid stays high afterwards until the next call or a drain
  task automatic send_byte(input logic [7:0] b);
    int gap, r;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tx_count++;
  endtask

  task automatic send_frame(input frame_kind_t fk, input int len);
    logic [7:0]  frame_bytes [$];
    logic [7:0]  cmd, pb, sum_lo, sum_hi, tail_a, tail_b;
    logic [15:0] sum;
    bit          hidden;
    int          lim;
    lim = frame_limit();
    hidden = 1'b0;
    // repeated first header byte ahead of the real header
    if (fk == FRAME_GOOD && $urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(sb.h1);
    frame_bytes.push_back(sb.h1);
    frame_bytes.push_back(sb.h2);
    if (fk == FRAME_OVERSIZE) begin
      // with cmd = h1 and len = h2 the re-scan finds a header inside the dropped start
      hidden = (sb.h2 > lim) && ($urandom_range(0, 1) == 1);
      frame_bytes.push_back(hidden ? sb.h1 : 8'($urandom_range(0, 255)));
      frame_bytes.push_back(hidden ? sb.h2 : 8'($urandom_range(lim + 1, 255)));
    end
    if (fk != FRAME_OVERSIZE || hidden) begin
      cmd = 8'($urandom_range(0, 255));
      sum = {8'h00, cmd} + 16'(len);
      frame_bytes.push_back(cmd);
      frame_bytes.push_back(8'(len));
      repeat (len) begin
        pb = 8'($urandom_range(0, 255));
        sum = sum + {8'h00, pb};
        frame_bytes.push_back(pb);
      end
      sum_lo = sum[7:0];
      sum_hi = sum[15:8];
      tail_a = sb.h2;
      tail_b = sb.h1;
      if (fk == FRAME_BAD_SUM) begin
        if ($urandom_range(0, 1) == 1) sum_lo ^= 8'($urandom_range(1, 255));
        else sum_hi ^= 8'($urandom_range(1, 255));
      end
      if (fk == FRAME_BAD_TAIL) begin
        if ($urandom_range(0, 1) == 1) tail_a ^= 8'($urandom_range(1, 255));
        else tail_b ^= 8'($urandom_range(1, 255));
      end
      frame_bytes.push_back(sum_lo);
      frame_bytes.push_back(sum_hi);
      frame_bytes.push_back(tail_a);
      frame_bytes.push_back(tail_b);
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  // mostly well-formed frames, some broken ones and a little noise
  task automatic random_item();
    int r, lim;
    lim = frame_limit();
    tx_burst = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 62) send_frame(FRAME_GOOD, pick_len(lim));
    else if (r < 72) send_frame(FRAME_BAD_SUM, pick_len(lim));
    else if (r < 82) send_frame(FRAME_BAD_TAIL, pick_len(lim));
    else if (r < 92) send_frame(FRAME_OVERSIZE, pick_len(lim));
    else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
  endtask

  // stop offering, then wait for every owed result and let the front side settle
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all three registers, one write per cycle
  task automatic write_config(input logic [7:0] h1, input logic [7:0] h2,
                              input logic [6:0] ml);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    idx = '{CFG_HEAD_FIRST, CFG_HEAD_SECOND, CFG_MAX_LEN};
    val = '{h1, h2, {1'b0, ml}};
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] h1, input logic [7:0] h2, input logic [6:0] ml);
    int target;
    wait_drain();
    write_config(h1, h2, ml);
    target = tx_count + PHASE_ITEMS;
    while (tx_count < target) random_item();
  endtask

  initial begin : stimulus
    logic [7:0] opening [$];
    logic [7:0] rh1, rh2;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    tx_burst = 1'b0;
    tx_count = 0;
    quiet_cycles = 0;
    rx_hold_len = 0;
    rx_holding = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset header pair and limit
    opening = '{
      // repeated first header byte, zero-length frame, extreme command
      8'hAA, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA,
      // length byte over the limit: frame start dropped and re-scanned
      8'hAA, 8'h55, 8'h00, 8'hFF,
      // bad sum on a zero-length frame: dropped without a result
      8'hAA, 8'h55, 8'h01, 8'h00, 8'h00, 8'h00, 8'h55, 8'hAA
    };
    foreach (opening[i]) send_byte(opening[i]);

    // largest payload once
    send_frame(FRAME_GOOD, MAX_PAYLOAD);

    // receiver holds off while short frames keep coming: the block fills and stalls
    wait_drain();
    rx_hold_len = HOLD_CYCLES;
    wait (rx_holding);
    @(posedge clk);
    tx_burst = 1'b1;
    repeat (6) send_frame(FRAME_GOOD, $urandom_range(0, 8));
    tx_burst = 1'b0;

    // random part over several register settings, extremes among them
    run_phase(8'hAA, 8'h55, 7'd120);
    run_phase(8'h00, 8'hFF, 7'd0);
    run_phase(8'hFF, 8'h00, 7'd127);
    rh1 = 8'($urandom_range(0, 255));
    do rh2 = 8'($urandom_range(17, 255)); while (rh2 == rh1);
    run_phase(rh1, rh2, 7'd16);
    run_phase(8'h3C, 8'h3C, 7'd40);
    run_phase(8'hAA, 8'h55, 7'd120);

    wait_drain();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sync_length_checksum_deframer_top.f =====
rtl/core/slcd_pkg.sv
rtl/core/slcd_in_if.sv
rtl/core/slcd_out_if.sv
rtl/core/slcd_ram.sv
rtl/core/slcd_front.sv
rtl/core/slcd_fifo.sv
rtl/core/slcd_back.sv
rtl/core/sync_length_checksum_deframer_top.sv
tb/sv/tb_sync_length_checksum_deframer_top.sv
